>>> hdl/line_pixel_generator_core_assert.svh
// ----------------------------------------------------------------------------
// line pixel generator assertion macros
// concurrent property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define LPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line pixel generator check failed");

// next-cycle implication, off during reset
`define LPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line pixel generator check failed");

// next-cycle implication, live during reset
`define LPG_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line pixel generator reset check failed");

`endif

>>> hdl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// shared types and constants of the line pixel generator
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } reg_idx_t;

  localparam logic [15:0] MAX_X_RESET = 16'd479;
  localparam logic [15:0] MAX_Y_RESET = 16'd319;

  localparam logic [7:0] RB_MASK = 8'hF8;
  localparam logic [7:0] G_MASK  = 8'hFC;

  typedef struct packed {
    logic [31:0] panel_word;
    logic [15:0] pixel_y;
    logic [15:0] pixel_x;
    logic        on_screen;
    logic        last;
  } pix_t;

  function automatic logic [31:0] panel_of(input logic [15:0] colour);
    logic [15:0] c;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    c = {colour[7:0], colour[15:8]};
    r = c[15:8] & RB_MASK;
    g = c[10:3] & G_MASK;
    b = {c[4:0], 3'b000} & RB_MASK;
    return {b, g, r, 8'h00};
  endfunction

endpackage

`default_nettype wire

>>> hdl/line_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// Bresenham line rasterizer with stream in and stream out
//
// in channel: a start transfer (in_tuser = 0) loads both endpoints and the
//   colour and yields the first pixel; an advance transfer (in_tuser = 1)
//   takes one step and yields the next pixel. an advance while no line is
//   active yields nothing.
// out channel: one pixel per result, out_tlast on the end point, out_tuser
//   set when the pixel lies inside max_x / max_y.
// output: each result is registered in the output stage before out_tvalid shows it.
// throughput: one item per cycle while in_tready is high, set by the single
//   step compare and add on the error term and position registers.
// cfg port: cfg_we writes max_x (index 0) or max_y (index 1) at once.
// reset: synchronous rst_n clears the line state (idle), empties the output
//   stages and restores max_x = 479, max_y = 319.
// stall: while out_tready is low the pending pixel holds; one more result
//   goes into a skid register, after which in_tready drops until that
//   register moves on into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // start_x, start_y, end_x, end_y, colour
  input  wire logic [79:0] in_tdata,
  // operation
  input  wire logic [0:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // pixel_x, pixel_y, panel_word
  output      logic [63:0] out_tdata,
  // on_screen
  output      logic [0:0]  out_tuser,
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import lpg_pkg::*;

  logic [15:0] max_x_r, max_y_r;
  logic [15:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [15:0] goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [16:0] delta_x_r, delta_x_nxt, neg_delta_y_r, neg_delta_y_nxt;
  logic        step_x_neg_r, step_x_neg_nxt, step_y_neg_r, step_y_neg_nxt;
  logic [18:0] error_term_r, error_term_nxt;
  logic [15:0] line_colour_r, line_colour_nxt;
  logic        active_r, active_nxt;

  logic        out_valid_r, skid_valid_r;
  pix_t        out_r, skid_r;

  op_t         op;
  logic        accept;
  logic        res_valid;
  pix_t        res;

  logic [15:0] x0, y0, x1, y1;
  logic        x_lt, y_lt;
  logic [15:0] dx16, dy16;
  logic [16:0] ndy17;
  logic signed [19:0] twice, ndy20, dx20, err_sum;
  logic        move_x, move_y;
  logic        at_end;

  assign op     = op_t'(in_tuser[0]);
  assign accept = in_tvalid && in_tready;
  assign in_tready = !skid_valid_r;

  assign x0 = in_tdata[15:0];
  assign y0 = in_tdata[31:16];
  assign x1 = in_tdata[47:32];
  assign y1 = in_tdata[63:48];

  assign x_lt  = x0 < x1;
  assign y_lt  = y0 < y1;
  assign dx16  = x_lt ? (x1 - x0) : (x0 - x1);
  assign dy16  = y_lt ? (y1 - y0) : (y0 - y1);
  assign ndy17 = 17'd0 - {1'b0, dy16};

  assign twice  = signed'({error_term_r, 1'b0});
  assign ndy20  = signed'({{3{neg_delta_y_r[16]}}, neg_delta_y_r});
  assign dx20   = signed'({{3{delta_x_r[16]}}, delta_x_r});
  assign move_x = twice >= ndy20;
  assign move_y = twice <= dx20;
  assign err_sum = signed'({error_term_r[18], error_term_r})
                   + (move_x ? ndy20 : 20'sd0) + (move_y ? dx20 : 20'sd0);

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    goal_x_nxt      = goal_x_r;
    goal_y_nxt      = goal_y_r;
    delta_x_nxt     = delta_x_r;
    neg_delta_y_nxt = neg_delta_y_r;
    step_x_neg_nxt  = step_x_neg_r;
    step_y_neg_nxt  = step_y_neg_r;
    error_term_nxt  = error_term_r;
    line_colour_nxt = line_colour_r;
    active_nxt      = active_r;
    res_valid       = 1'b0;
    if (accept) begin
      if (op == OP_START) begin
        cur_x_nxt       = x0;
        cur_y_nxt       = y0;
        goal_x_nxt      = x1;
        goal_y_nxt      = y1;
        step_x_neg_nxt  = !x_lt;
        step_y_neg_nxt  = !y_lt;
        delta_x_nxt     = {1'b0, dx16};
        neg_delta_y_nxt = ndy17;
        error_term_nxt  = {3'b000, dx16} + {{2{ndy17[16]}}, ndy17};
        line_colour_nxt = in_tdata[79:64];
        res_valid       = 1'b1;
      end else if (active_r) begin
        if (move_x) begin
          cur_x_nxt = step_x_neg_r ? (cur_x_r - 16'd1) : (cur_x_r + 16'd1);
        end
        if (move_y) begin
          cur_y_nxt = step_y_neg_r ? (cur_y_r - 16'd1) : (cur_y_r + 16'd1);
        end
        error_term_nxt = err_sum[18:0];
        res_valid      = 1'b1;
      end
    end
    at_end = (cur_x_nxt == goal_x_nxt) && (cur_y_nxt == goal_y_nxt);
    if (res_valid) begin
      active_nxt = !at_end;
    end
    res.pixel_x    = cur_x_nxt;
    res.pixel_y    = cur_y_nxt;
    res.on_screen  = (cur_x_nxt <= max_x_r) && (cur_y_nxt <= max_y_r);
    res.panel_word = panel_of(line_colour_nxt);
    res.last       = at_end;
  end

  // line state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r       <= MAX_X_RESET;
      max_y_r       <= MAX_Y_RESET;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      delta_x_r     <= '0;
      neg_delta_y_r <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      error_term_r  <= '0;
      line_colour_r <= '0;
      active_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index[0]))
          REG_MAX_X: max_x_r <= cfg_wdata;
          REG_MAX_Y: max_y_r <= cfg_wdata;
          default: ;
        endcase
      end
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      goal_x_r      <= goal_x_nxt;
      goal_y_r      <= goal_y_nxt;
      delta_x_r     <= delta_x_nxt;
      neg_delta_y_r <= neg_delta_y_nxt;
      step_x_neg_r  <= step_x_neg_nxt;
      step_y_neg_r  <= step_y_neg_nxt;
      error_term_r  <= error_term_nxt;
      line_colour_r <= line_colour_nxt;
      active_r      <= active_nxt;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.panel_word, out_r.pixel_y, out_r.pixel_x};
  assign out_tuser  = out_r.on_screen;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire

>>> hdl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// port level checks of the line pixel generator, bound to line_pixel_generator_core
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast
);
  `include "line_pixel_generator_core_assert.svh"

  // nothing pending after reset
  `LPG_ASSERT_NXT_RST(a_reset_empty, !rst_n, !out_tvalid)
  // input only blocks while a result is waiting
  `LPG_ASSERT_IMP(a_block_needs_out, !in_tready, out_tvalid)
  // a start transfer with the sink ready gives a pixel next cycle
  `LPG_ASSERT_NXT(a_start_result, in_tvalid && in_tready && !in_tuser[0] && out_tready,
    out_tvalid)
  // stalled pixel holds
  `LPG_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
